// ----- rtl/rfr_pkg.sv -----
package rfr_pkg;

  localparam int BufDepthDef = 32;

  localparam logic [7:0] START_BYTE    = 8'h7F;
  localparam logic [7:0] CODE_PRESENCE = 8'h90;
  localparam logic [7:0] CODE_BLOCK    = 8'h91;
  localparam logic [7:0] STATUS_GOOD   = 8'h00;

  // Fixed positions in the payload store.
  localparam int PosCode   = 1;
  localparam int PosStatus = 2;
  localparam int BlockBase = 9;

  // Configuration port.
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_CHECK_LEN = '0;

  typedef enum logic [1:0] {
    ACT_RX     = 2'd0,
    ACT_STATUS = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_DATA    = 2'd2,
    ST_LED     = 2'd3
  } status_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } store_wr_t;

endpackage

// ----- rtl/rfr_if.sv -----
interface rfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic [1:0] flag_value;
  logic [3:0] block_index;

  modport source (output valid, action, rx_byte, flag_value, block_index, input ready);
  modport sink   (input valid, action, rx_byte, flag_value, block_index, output ready);
endinterface

interface rfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] card_status;
  logic       frame_done;
  logic       frame_ok;
  logic [7:0] read_data;

  modport source (output valid, card_status, frame_done, frame_ok, read_data, input ready);
  modport sink   (input valid, card_status, frame_done, frame_ok, read_data, output ready);
endinterface

// ----- rtl/rfr_store.sv -----
module rfr_store
  import rfr_pkg::*;
#(
  parameter int BUF_DEPTH = BufDepthDef,
  localparam int AW = $clog2(BUF_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  store_wr_t     wr,
  input  logic [AW-1:0] wr_addr,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data_r
);

  logic [7:0] mem [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // A write at the same edge as the read is forwarded, so the reading item
  // sees the byte stored by the item just ahead of it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else if (vld_r[rd_addr]) begin
        rd_data_r <= mem[rd_addr];
      end else begin
        rd_data_r <= 8'h00;
      end
    end
  end

endmodule

// ----- rtl/rfr_core.sv -----
module rfr_core
  import rfr_pkg::*;
#(
  parameter int BUF_DEPTH = BufDepthDef,
  localparam int AW = $clog2(BUF_DEPTH),
  localparam int IW = $clog2(BUF_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  action_t       action,
  input  logic [7:0]    rx_byte,
  input  logic [1:0]    flag_value,
  input  logic [7:0]    blk_data,
  input  logic          check_len,
  output store_wr_t     wr,
  output logic [AW-1:0] wr_addr,
  output logic [1:0]    card_status,
  output logic          frame_done,
  output logic          frame_ok,
  output logic [7:0]    read_data
);

  logic          in_frame_r, in_frame_nxt;
  logic [6:0]    left_r, left_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic          ovf_r, ovf_nxt;
  status_t       status_r, status_nxt;
  logic [7:0]    code_r, code_nxt;
  logic [7:0]    st_r, st_nxt;
  logic          ok;

  always_comb begin
    in_frame_nxt = in_frame_r;
    left_nxt     = left_r;
    idx_nxt      = idx_r;
    xor_nxt      = xor_r;
    ovf_nxt      = ovf_r;
    status_nxt   = status_r;
    code_nxt     = code_r;
    st_nxt       = st_r;
    wr.en        = 1'b0;
    wr.data      = rx_byte;
    frame_done   = 1'b0;
    ok           = 1'b0;
    read_data    = 8'h00;
    case (action)
      ACT_RX: begin
        if (!in_frame_r) begin
          if (rx_byte == START_BYTE) begin
            in_frame_nxt = 1'b1;
            left_nxt     = '0;
            idx_nxt      = '0;
            xor_nxt      = '0;
            ovf_nxt      = 1'b0;
          end
        end else if (left_r == 7'd0) begin
          // Length byte; out-of-range values leave the length still awaited.
          if (rx_byte < START_BYTE) begin
            left_nxt = rx_byte[6:0];
            xor_nxt  = check_len ? rx_byte : 8'h00;
          end
        end else if (left_r > 7'd1) begin
          left_nxt = left_r - 7'd1;
          xor_nxt  = xor_r ^ rx_byte;
          if (idx_r < IW'(BUF_DEPTH)) begin
            // The store is written only when the item really moves on.
            wr.en   = step;
            idx_nxt = idx_r + IW'(1);
            if (idx_r == IW'(PosCode)) begin
              code_nxt = rx_byte;
            end
            if (idx_r == IW'(PosStatus)) begin
              st_nxt = rx_byte;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
        end else begin
          frame_done   = 1'b1;
          ok           = !ovf_r && (xor_r == rx_byte);
          in_frame_nxt = 1'b0;
          left_nxt     = '0;
          idx_nxt      = '0;
          if (ok) begin
            if (code_r == CODE_PRESENCE) begin
              if (status_r != ST_LED) begin
                status_nxt = (st_r == STATUS_GOOD) ? ST_PRESENT : ST_NONE;
              end
            end else if (code_r == CODE_BLOCK) begin
              status_nxt = (st_r == STATUS_GOOD) ? ST_DATA : ST_NONE;
            end else if (status_r != ST_LED) begin
              status_nxt = ST_NONE;
            end
          end
        end
      end
      ACT_STATUS: begin
        status_nxt = status_t'(flag_value);
      end
      ACT_READ: begin
        read_data = blk_data;
      end
      default: begin
      end
    endcase
  end

  assign wr_addr     = idx_r[AW-1:0];
  assign card_status = status_nxt;
  assign frame_ok    = ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      left_r     <= '0;
      idx_r      <= '0;
      xor_r      <= '0;
      ovf_r      <= 1'b0;
      status_r   <= ST_NONE;
      code_r     <= '0;
      st_r       <= '0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      left_r     <= left_nxt;
      idx_r      <= idx_nxt;
      xor_r      <= xor_nxt;
      ovf_r      <= ovf_nxt;
      status_r   <= status_nxt;
      code_r     <= code_nxt;
      st_r       <= st_nxt;
    end
  end

endmodule

// ----- rtl/rfid_reply_frame_receiver.sv -----
// Reply frame receiver: assembles reader reply frames and keeps the card status.
// Items pass the input register, then the result register once that is empty
// or its item is taken. Throughput: one item per cycle while results are taken,
// as both registers then move; the block store read is issued on acceptance.
// Reset (rst_n low at a clock edge) clears the frame state, the status, the
// store's valid bits, the register and both pipeline valid flags.
module rfid_reply_frame_receiver
  import rfr_pkg::*;
#(
  parameter int BUF_DEPTH = BufDepthDef,
  localparam int AW = $clog2(BUF_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  rfr_in_if.sink            in_ch,
  rfr_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic       check_len_r;
  logic       s1_valid_r;
  action_t    s1_action_r;
  logic [7:0] s1_rx_r;
  logic [1:0] s1_flag_r;
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic       out_done_r;
  logic       out_ok_r;
  logic [7:0] out_rd_r;

  logic          in_fire;
  logic          s1_adv;
  store_wr_t     wr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    blk_data;
  logic [1:0]    res_status;
  logic          res_done;
  logic          res_ok;
  logic [7:0]    res_rd;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_CHECK_LEN) ? {31'b0, check_len_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_len_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_CHECK_LEN)) begin
      check_len_r <= cfg_pwdata[0];
    end
  end

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rd_addr     = AW'(BlockBase) + AW'(in_ch.block_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= action_t'(in_ch.action);
      s1_rx_r     <= in_ch.rx_byte;
      s1_flag_r   <= in_ch.flag_value;
    end
  end

  rfr_store #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .rd_en     (in_fire),
    .rd_addr   (rd_addr),
    .rd_data_r (blk_data)
  );

  rfr_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .action      (s1_action_r),
    .rx_byte     (s1_rx_r),
    .flag_value  (s1_flag_r),
    .blk_data    (blk_data),
    .check_len   (check_len_r),
    .wr          (wr),
    .wr_addr     (wr_addr),
    .card_status (res_status),
    .frame_done  (res_done),
    .frame_ok    (res_ok),
    .read_data   (res_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= res_status;
      out_done_r   <= res_done;
      out_ok_r     <= res_ok;
      out_rd_r     <= res_rd;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.card_status = out_status_r;
  assign out_ch.frame_done  = out_done_r;
  assign out_ch.frame_ok    = out_ok_r;
  assign out_ch.read_data   = out_rd_r;

endmodule

// ----- rtl/rfr_checker.sv -----
module rfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_card_status,
  input logic       out_frame_done,
  input logic       out_frame_ok,
  input logic [7:0] out_read_data
);

  // A passing frame is always an ended frame.
  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_ok |-> out_frame_done)
    else $error("frame_ok without frame_done");

  // A block read never ends a frame.
  a_read_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_data != 8'h00) |-> !out_frame_done)
    else $error("read data on a frame-ending item");

  // The input side is never held off while the result side takes items.
  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_card_status)
      && $stable(out_frame_done) && $stable(out_frame_ok) && $stable(out_read_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rfid_reply_frame_receiver rfr_checker u_rfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_card_status (out_ch.card_status),
  .out_frame_done  (out_ch.frame_done),
  .out_frame_ok    (out_ch.frame_ok),
  .out_read_data   (out_ch.read_data)
);

// ----- tb/rfid_reply_frame_receiver_tb.sv -----
module rfid_reply_frame_receiver_tb;
  import rfr_pkg::*;

  typedef struct packed {
    status_t    card_status;
    logic       frame_done;
    logic       frame_ok;
    logic [7:0] read_data;
  } reply_t;

  // Tracks frame assembly and card status, and holds the replies still due.
  class reply_scoreboard;
    bit        len_in_check;
    bit        in_frame;
    bit [6:0]  bytes_left;
    bit [5:0]  store_index;
    bit [7:0]  running_xor;
    bit        overflowed;
    bit [7:0]  store [BufDepthDef];
    status_t   status;
    reply_t    expected_replies[$];
    int        n_frames;
    int        n_accepted;
    int        n_overflowed;
    int        n_reads;
    int        n_results;

    function new();
      status = ST_NONE;
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function void apply_reply();
      if (store[PosCode] == CODE_PRESENCE) begin
        // A lit LED is not overwritten by a presence reply.
        if (status != ST_LED) status = (store[PosStatus] == STATUS_GOOD) ? ST_PRESENT : ST_NONE;
      end else if (store[PosCode] == CODE_BLOCK) begin
        status = (store[PosStatus] == STATUS_GOOD) ? ST_DATA : ST_NONE;
      end else if (status != ST_LED) begin
        status = ST_NONE;
      end
    endfunction

    function void take_byte(logic [7:0] b, inout reply_t r);
      if (!in_frame) begin
        if (b == START_BYTE) begin
          in_frame = 1'b1;
          bytes_left = 7'd0;
          store_index = 6'd0;
          running_xor = 8'h00;
          overflowed = 1'b0;
        end
      end else if (bytes_left == 7'd0) begin
        if (b < START_BYTE) begin
          bytes_left = b[6:0];
          running_xor = len_in_check ? b : 8'h00;
        end
      end else if (bytes_left > 7'd1) begin
        bytes_left--;
        running_xor ^= b;
        if (store_index < 6'(BufDepthDef)) begin
          store[store_index] = b;
          store_index++;
        end else begin
          overflowed = 1'b1;
        end
      end else begin
        r.frame_done = 1'b1;
        r.frame_ok = !overflowed && (running_xor == b);
        in_frame = 1'b0;
        bytes_left = 7'd0;
        store_index = 6'd0;
        n_frames++;
        if (overflowed) n_overflowed++;
        if (r.frame_ok) begin
          n_accepted++;
          apply_reply();
        end
      end
    endfunction

    function void note_item(action_t act, logic [7:0] rx, logic [1:0] flag, logic [3:0] blk);
      reply_t r;
      r = '0;
      case (act)
        ACT_RX: take_byte(rx, r);
        ACT_STATUS: status = status_t'(flag);
        ACT_READ: begin
          r.read_data = store[BlockBase + int'(blk)];
          n_reads++;
        end
        default: ;
      endcase
      r.card_status = status;
      expected_replies.push_back(r);
    endfunction

    function string check_result(reply_t got);
      reply_t want;
      string  msg;
      if (expected_replies.size() == 0) begin
        return $sformatf("unexpected result: status %0d done %0b ok %0b data %02h",
                         got.card_status, got.frame_done, got.frame_ok, got.read_data);
      end
      want = expected_replies.pop_front();
      n_results++;
      msg = "";
      if (got.card_status !== want.card_status)
        msg = {msg, $sformatf(" card_status %0d/%0d", got.card_status, want.card_status)};
      if (got.frame_done !== want.frame_done)
        msg = {msg, $sformatf(" frame_done %0b/%0b", got.frame_done, want.frame_done)};
      if (got.frame_ok !== want.frame_ok)
        msg = {msg, $sformatf(" frame_ok %0b/%0b", got.frame_ok, want.frame_ok)};
      if (got.read_data !== want.read_data)
        msg = {msg, $sformatf(" read_data %02h/%02h", got.read_data, want.read_data)};
      if (msg != "") msg = $sformatf("result %0d (got/expected):%s", n_results, msg);
      return msg;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  rfr_in_if  in_ch ();
  rfr_out_if out_ch ();

  rfid_reply_frame_receiver DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  reply_scoreboard board;
  int n_errors;
  int items_sent;
  int hold_request;
  int n_cfg_writes;
  bit src_steady;
  bit snk_steady;
  bit len_check;

  always #1 clk = ~clk;

  task automatic report(string msg);
    n_errors++;
    if (n_errors <= 20) $display("mismatch: %s", msg);
  endtask

  // Valid is only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_item(action_t act, logic [7:0] rx, logic [1:0] flag, logic [3:0] blk);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 49) == 0) src_steady = !src_steady;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.rx_byte     <= rx;
    in_ch.flag_value  <= flag;
    in_ch.block_index <= blk;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(act, rx, flag, blk);
    items_sent++;
  endtask

  task automatic send_rx(logic [7:0] b);
    send_item(ACT_RX, b, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
  endtask

  task automatic send_side_item();
    case ($urandom_range(0, 2))
      0: send_item(ACT_STATUS, 8'($urandom), 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
      1: send_item(ACT_READ, 8'($urandom), 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
      default: send_item(ACT_NONE, 8'($urandom), 2'($urandom_range(0, 3)),
                         4'($urandom_range(0, 15)));
    endcase
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 3) == 0) send_rx(8'($urandom));
    else send_side_item();
  endtask

  // A well-formed frame with random content; a few have a bad length byte first,
  // a wrong checksum, or more payload than the store holds.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  body[$];
    logic [7:0]  sum;
    logic [7:0]  b;
    pick = $urandom_range(0, 63);
    if (pick == 0) len = $urandom_range(110, 126);
    else if (pick <= 3) len = $urandom_range(34, 60);
    else if (pick <= 6) len = $urandom_range(27, 33);
    else len = $urandom_range(1, 26);
    sum = len_check ? 8'(len) : 8'h00;
    for (int j = 0; j < int'(len) - 1; j++) begin
      if (j == PosCode) begin
        case ($urandom_range(0, 3))
          0, 1: b = CODE_PRESENCE;
          2: b = CODE_BLOCK;
          default: b = 8'($urandom);
        endcase
      end else if (j == PosStatus) begin
        b = ($urandom_range(0, 9) < 7) ? STATUS_GOOD : 8'($urandom);
      end else begin
        b = ($urandom_range(0, 15) == 0) ? START_BYTE : 8'($urandom);
      end
      body.push_back(b);
      sum ^= b;
    end
    if ($urandom_range(0, 7) == 0) sum ^= 8'($urandom_range(1, 255));
    send_rx(START_BYTE);
    case ($urandom_range(0, 19))
      0: send_rx(8'($urandom_range(127, 255)));
      1: send_rx(8'h00);
      default: ;
    endcase
    send_rx(8'(len));
    foreach (body[j]) begin
      if ($urandom_range(0, 11) == 0) send_side_item();
      send_rx(body[j]);
    end
    send_rx(sum);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes the checksum mode, then reads it back.
  task automatic set_length_check(bit v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_CHECK_LEN;
    cfg_pwdata  <= {31'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[0] !== v) report($sformatf("register read back %0b, wrote %0b", cfg_prdata[0], v));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    board.len_in_check = v;
    len_check = v;
    n_cfg_writes++;
  endtask

  initial begin : result_sink
    int     gap;
    int     n;
    reply_t got;
    string  msg;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      gap = snk_steady ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 49) == 0) snk_steady = !snk_steady;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.card_status = status_t'(out_ch.card_status);
      got.frame_done  = out_ch.frame_done;
      got.frame_ok    = out_ch.frame_ok;
      got.read_data   = out_ch.read_data;
      msg = board.check_result(got);
      if (msg != "") report(msg);
    end
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int target;
    board = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_RX;
    in_ch.rx_byte     <= 8'h00;
    in_ch.flag_value  <= 2'd0;
    in_ch.block_index <= 4'd0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= REG_CHECK_LEN;
    cfg_pwdata        <= 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset checksum mode (length byte not covered).
    send_rx(8'h13);
    send_rx(START_BYTE);
    send_rx(8'hFF);
    send_rx(START_BYTE);
    send_rx(8'h00);
    send_rx(8'h01);
    send_rx(8'h00);
    // Presence reply whose first payload byte equals the start byte.
    send_rx(START_BYTE);
    send_rx(8'h04);
    send_rx(START_BYTE);
    send_rx(CODE_PRESENCE);
    send_rx(STATUS_GOOD);
    send_rx(START_BYTE ^ CODE_PRESENCE ^ STATUS_GOOD);
    send_item(ACT_STATUS, 8'h00, ST_LED, 4'h0);
    send_item(ACT_NONE, 8'hFF, 2'b11, 4'hF);
    // Presence reply must leave the lit LED alone.
    send_rx(START_BYTE);
    send_rx(8'h04);
    send_rx(8'h00);
    send_rx(CODE_PRESENCE);
    send_rx(STATUS_GOOD);
    send_rx(CODE_PRESENCE);
    // Block reply with a bad status clears even a lit LED.
    send_rx(START_BYTE);
    send_rx(8'h04);
    send_rx(8'h00);
    send_rx(CODE_BLOCK);
    send_rx(8'h05);
    send_rx(CODE_BLOCK ^ 8'h05);
    send_item(ACT_READ, 8'h00, 2'd0, 4'h0);
    send_item(ACT_READ, 8'hFF, 2'd3, 4'hF);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      set_length_check(phase % 2 == 0);
      if (phase == 2) begin
        // Long receiver stall while the sender keeps going back to back.
        hold_request = 300;
        src_steady = 1'b1;
      end
      target = items_sent + 280;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 7) send_random_frame();
        else send_noise();
      end
      settle();
    end

    $display("Sent %0d items across %0d checksum mode writes; %0d frames ended, %0d accepted, %0d overflowed.",
             items_sent, n_cfg_writes, board.n_frames, board.n_accepted, board.n_overflowed);
    $display("Block reads: %0d; results checked: %0d; mismatches: %0d.",
             board.n_reads, board.n_results, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rfr_pkg.sv
rtl/rfr_if.sv
rtl/rfr_store.sv
rtl/rfr_core.sv
rtl/rfid_reply_frame_receiver.sv
rtl/rfr_checker.sv
tb/rfid_reply_frame_receiver_tb.sv
